@@ hdl/ssdf_pkg.sv @@
package ssdf_pkg;

	localparam int DIGITS = 4;

	typedef enum logic [1:0] {
		OP_NUMBER  = 2'd0,
		OP_CHARS   = 2'd1,
		OP_CHAR    = 2'd2,
		OP_CONTROL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_STOP  = 2'd2
	} kind_t;

	localparam logic [7:0] CMD_DATA = 8'h40;
	localparam logic [7:0] CMD_ADDR = 8'hC0;
	localparam logic [7:0] CMD_CTRL = 8'h80;
	localparam logic [7:0] COLON_BIT = 8'h80;

	localparam logic [4:0] IDX_P     = 5'd16;
	localparam logic [4:0] IDX_DASH  = 5'd17;
	localparam logic [4:0] IDX_BLANK = 5'd18;

	// last symbol index of each request kind
	localparam logic [3:0] LAST_FULL    = 4'd12;
	localparam logic [3:0] LAST_CHAR    = 4'd9;
	localparam logic [3:0] LAST_CONTROL = 4'd2;

	typedef struct packed {
		op_t               op;
		logic signed [14:0] number;
		logic              colon;
		logic [31:0]       four_chars;
		logic [1:0]        position;
		logic [7:0]        character;
		logic [2:0]        brightness;
		logic              display_enable;
	} req_t;

	typedef struct packed {
		op_t         op;
		logic        colon;
		logic        neg;
		logic        err;
		logic [13:0] mag;
		logic [6:0]  hund;
		logic [31:0] four_chars;
		logic [1:0]  position;
		logic [7:0]  character;
		logic [2:0]  brightness;
		logic        display_enable;
	} prep_t;

	typedef struct packed {
		op_t                    op;
		logic                   err;
		logic [7:0]             addr;
		logic [DIGITS-1:0][7:0] seg;
		logic [2:0]             brightness;
		logic                   display_enable;
	} frame_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
		logic       err;
	} sym_t;

	function automatic logic [7:0] seg_code(input logic [4:0] idx);
		logic [7:0] s;
		case (idx)
			5'd0:  s = 8'h3f;
			5'd1:  s = 8'h06;
			5'd2:  s = 8'h5b;
			5'd3:  s = 8'h4f;
			5'd4:  s = 8'h66;
			5'd5:  s = 8'h6d;
			5'd6:  s = 8'h7d;
			5'd7:  s = 8'h07;
			5'd8:  s = 8'h7f;
			5'd9:  s = 8'h6f;
			5'd10: s = 8'h77;
			5'd11: s = 8'h7c;
			5'd12: s = 8'h39;
			5'd13: s = 8'h5e;
			5'd14: s = 8'h79;
			5'd15: s = 8'h71;
			5'd16: s = 8'h73;
			5'd17: s = 8'h40;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [4:0] char_index(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39)
			r = 5'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46)
			r = 5'(c - 8'h37);
		else if (c == 8'h50)
			r = IDX_P;
		else if (c == 8'h2d)
			r = IDX_DASH;
		else
			r = IDX_BLANK;
		return r;
	endfunction

	// split 0..99 into tens and ones: {tens, ones}
	function automatic logic [7:0] dec_split(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  ones;
		p = 15'(x) * 15'd205;
		tens = p[14:11];
		ones = x - 7'(7'(tens) * 7'd10);
		return {tens, ones[3:0]};
	endfunction

endpackage

@@ hdl/ssdf_prep.sv @@
module ssdf_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ssdf_pkg::req_t    in_req,
	output logic              in_ready,
	output logic              out_valid,
	output ssdf_pkg::prep_t   out_data,
	input  logic              out_ready
);

	logic               valid_s2;
	ssdf_pkg::prep_t    data_s2;
	ssdf_pkg::prep_t    nxt;
	logic [14:0]        mag15;
	logic [26:0]        prod;
	logic               neg;

	assign neg   = in_req.number[14];
	assign mag15 = neg ? 15'(-in_req.number) : 15'(in_req.number);
	// floor(mag / 100), exact below 10000
	assign prod  = 27'(mag15[13:0]) * 27'd5243;

	always_comb begin
		nxt.op             = in_req.op;
		nxt.colon          = in_req.colon;
		nxt.neg            = neg;
		nxt.err            = (in_req.op == ssdf_pkg::OP_NUMBER) &&
			((in_req.number < -15'sd999) || (in_req.number > 15'sd9999));
		nxt.mag            = mag15[13:0];
		nxt.hund           = prod[25:19];
		nxt.four_chars     = in_req.four_chars;
		nxt.position       = in_req.position;
		nxt.character      = in_req.character;
		nxt.brightness     = in_req.brightness;
		nxt.display_enable = in_req.display_enable;
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

endmodule

@@ hdl/ssdf_format.sv @@
module ssdf_format (
	input  ssdf_pkg::prep_t  in_data,
	output ssdf_pkg::frame_t frame
);

	logic [13:0] rem_w;
	logic [7:0]  hi_split;
	logic [7:0]  lo_split;
	logic [3:0]  raw [ssdf_pkg::DIGITS];
	logic [4:0]  idx [ssdf_pkg::DIGITS];
	logic [1:0]  dash_pos;
	logic        z1, z2, z3;
	logic [7:0]  extra;

	assign rem_w    = in_data.mag - 14'(14'(in_data.hund) * 14'd100);
	assign hi_split = ssdf_pkg::dec_split(in_data.hund);
	assign lo_split = ssdf_pkg::dec_split(rem_w[6:0]);

	assign raw[0] = hi_split[7:4];
	assign raw[1] = hi_split[3:0];
	assign raw[2] = lo_split[7:4];
	assign raw[3] = lo_split[3:0];

	assign z1 = (raw[1] == 4'd0);
	assign z2 = z1 && (raw[2] == 4'd0);
	assign z3 = z2 && (raw[3] == 4'd0);
	// minus sign slides right over leading zeros
	assign dash_pos = z3 ? 2'd3 : (z2 ? 2'd2 : (z1 ? 2'd1 : 2'd0));

	always_comb begin
		for (int i = 0; i < ssdf_pkg::DIGITS; i++) begin
			idx[i] = ssdf_pkg::IDX_BLANK;
		end
		case (in_data.op)
			ssdf_pkg::OP_NUMBER: begin
				if (in_data.err) begin
					for (int i = 0; i < ssdf_pkg::DIGITS; i++) begin
						idx[i] = ssdf_pkg::IDX_BLANK;
					end
				end else if (in_data.colon) begin
					idx[0] = in_data.neg ? ssdf_pkg::IDX_DASH : 5'(raw[0]);
					for (int i = 1; i < ssdf_pkg::DIGITS; i++) begin
						idx[i] = 5'(raw[i]);
					end
				end else if (in_data.neg) begin
					for (int i = 0; i < ssdf_pkg::DIGITS; i++) begin
						if (2'(i) < dash_pos)
							idx[i] = ssdf_pkg::IDX_BLANK;
						else if (2'(i) == dash_pos)
							idx[i] = ssdf_pkg::IDX_DASH;
						else
							idx[i] = 5'(raw[i]);
					end
				end else begin
					idx[0] = (raw[0] == 4'd0) ? ssdf_pkg::IDX_BLANK : 5'(raw[0]);
					idx[1] = (raw[0] == 4'd0 && z1) ? ssdf_pkg::IDX_BLANK : 5'(raw[1]);
					idx[2] = (raw[0] == 4'd0 && z2) ? ssdf_pkg::IDX_BLANK : 5'(raw[2]);
					idx[3] = 5'(raw[3]);
				end
			end
			ssdf_pkg::OP_CHARS: begin
				for (int i = 0; i < ssdf_pkg::DIGITS; i++) begin
					idx[i] = ssdf_pkg::char_index(in_data.four_chars[8*i +: 8]);
				end
			end
			ssdf_pkg::OP_CHAR: begin
				idx[0] = ssdf_pkg::char_index(in_data.character);
			end
			default: begin
			end
		endcase
	end

	assign extra = (in_data.op == ssdf_pkg::OP_NUMBER && in_data.colon) ?
		ssdf_pkg::COLON_BIT : 8'h00;

	always_comb begin
		frame.op             = in_data.op;
		frame.err            = in_data.err;
		frame.addr           = (in_data.op == ssdf_pkg::OP_CHAR) ?
			(ssdf_pkg::CMD_ADDR | 8'(in_data.position)) : ssdf_pkg::CMD_ADDR;
		frame.brightness     = in_data.brightness;
		frame.display_enable = in_data.display_enable;
		for (int i = 0; i < ssdf_pkg::DIGITS; i++) begin
			frame.seg[i] = ssdf_pkg::seg_code(idx[i]) | extra;
		end
	end

endmodule

@@ hdl/ssdf_emit.sv @@
module ssdf_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ssdf_pkg::frame_t  in_frame,
	output logic              in_ready,
	output logic              out_valid,
	output ssdf_pkg::sym_t    out_sym,
	input  logic              out_ready
);

	logic              frame_valid_q;
	ssdf_pkg::frame_t  frame_q;
	logic [3:0]        cnt_q;
	logic [7:0]        ctrl_q;
	logic [2:0]        bright_q;
	logic              on_q;
	logic              out_valid_q;
	ssdf_pkg::sym_t    out_q;
	ssdf_pkg::sym_t    cur;
	logic [3:0]        last_idx;
	logic              out_free;
	logic              step;
	logic              done;
	logic              load;

	always_comb begin
		cur.kind  = ssdf_pkg::KIND_DATA;
		cur.value = 8'h00;
		cur.err   = frame_q.err;
		case (frame_q.op)
			ssdf_pkg::OP_CONTROL: begin
				last_idx = ssdf_pkg::LAST_CONTROL;
				case (cnt_q)
					4'd0: cur.kind = ssdf_pkg::KIND_START;
					4'd1: cur.value = ctrl_q;
					default: cur.kind = ssdf_pkg::KIND_STOP;
				endcase
			end
			ssdf_pkg::OP_CHAR: begin
				last_idx = ssdf_pkg::LAST_CHAR;
				case (cnt_q)
					4'd0, 4'd3, 4'd7: cur.kind = ssdf_pkg::KIND_START;
					4'd2, 4'd6, 4'd9: cur.kind = ssdf_pkg::KIND_STOP;
					4'd1: cur.value = ssdf_pkg::CMD_DATA;
					4'd4: cur.value = frame_q.addr;
					4'd5: cur.value = frame_q.seg[0];
					4'd8: cur.value = ctrl_q;
					default: cur.kind = ssdf_pkg::KIND_STOP;
				endcase
			end
			default: begin
				last_idx = ssdf_pkg::LAST_FULL;
				case (cnt_q)
					4'd0, 4'd3, 4'd10: cur.kind = ssdf_pkg::KIND_START;
					4'd2, 4'd9, 4'd12: cur.kind = ssdf_pkg::KIND_STOP;
					4'd1: cur.value = ssdf_pkg::CMD_DATA;
					4'd4: cur.value = frame_q.addr;
					4'd5: cur.value = frame_q.seg[0];
					4'd6: cur.value = frame_q.seg[1];
					4'd7: cur.value = frame_q.seg[2];
					4'd8: cur.value = frame_q.seg[3];
					4'd11: cur.value = ctrl_q;
					default: cur.kind = ssdf_pkg::KIND_STOP;
				endcase
			end
		endcase
		cur.last = (cnt_q == last_idx);
	end

	assign out_free  = !out_valid_q || out_ready;
	assign step      = frame_valid_q && out_free;
	assign done      = step && (cnt_q == last_idx);
	assign in_ready  = !frame_valid_q || done;
	assign load      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_sym   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
			cnt_q         <= 4'd0;
			bright_q      <= 3'd4;
			on_q          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				frame_valid_q <= 1'b1;
				cnt_q         <= 4'd0;
				if (in_frame.op == ssdf_pkg::OP_CONTROL) begin
					bright_q <= in_frame.brightness;
					on_q     <= in_frame.display_enable;
				end
			end else if (done) begin
				frame_valid_q <= 1'b0;
			end else if (step) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= in_frame;
			// control byte follows the settings in effect after this request
			if (in_frame.op == ssdf_pkg::OP_CONTROL)
				ctrl_q <= ssdf_pkg::CMD_CTRL | {4'd0, in_frame.display_enable,
					in_frame.brightness};
			else
				ctrl_q <= ssdf_pkg::CMD_CTRL | {4'd0, on_q, bright_q};
		end
		if (step) begin
			out_q <= cur;
		end
	end

endmodule

@@ hdl/seven_segment_display_command_framer_core.sv @@
// channel   dir  tdata                          tuser                      tlast
// s_axis    in   request fields (62 used of 64) operation                  -
// m_axis    out  byte_value                     symbol_kind, range_error   last symbol
//
// One bus symbol leaves per cycle while m_axis is ready; a request takes 13 symbols
// (numbers, four characters), 10 (single character) or 3 (control), as set by the symbol
// sequencer. Requests pass the input, prep, sequencer frame and symbol output registers.
// The input register and the decimal split stage take the next requests while
// the sequencer emits. arst_n clears all handshake state; brightness resets to 4,
// display off. A stalled m_axis holds its symbol and backs up the whole pipe.
module seven_segment_display_command_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [14:0] number, [15] colon, [47:16] four_chars, [49:48] position,
	// [57:50] character, [60:58] brightness, [61] display_enable
	input  logic [63:0] s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] byte_value
	output logic [7:0]  m_axis_tdata,
	// [1:0] symbol_kind, [2] range_error
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	logic              valid_s1;
	ssdf_pkg::req_t    req_s1;
	logic              prep_ready;
	logic              prep_valid;
	ssdf_pkg::prep_t   prep_data;
	ssdf_pkg::frame_t  frame;
	logic              emit_ready;
	ssdf_pkg::sym_t    sym;

	assign s_axis_tready = !valid_s1 || prep_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.op             <= ssdf_pkg::op_t'(s_axis_tuser);
			req_s1.number         <= $signed(s_axis_tdata[14:0]);
			req_s1.colon          <= s_axis_tdata[15];
			req_s1.four_chars     <= s_axis_tdata[47:16];
			req_s1.position       <= s_axis_tdata[49:48];
			req_s1.character      <= s_axis_tdata[57:50];
			req_s1.brightness     <= s_axis_tdata[60:58];
			req_s1.display_enable <= s_axis_tdata[61];
		end
	end

	ssdf_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_req    (req_s1),
		.in_ready  (prep_ready),
		.out_valid (prep_valid),
		.out_data  (prep_data),
		.out_ready (emit_ready)
	);

	ssdf_format u_format (
		.in_data (prep_data),
		.frame   (frame)
	);

	ssdf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_frame  (frame),
		.in_ready  (emit_ready),
		.out_valid (m_axis_tvalid),
		.out_sym   (sym),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = sym.value;
	assign m_axis_tuser = {sym.err, sym.kind};
	assign m_axis_tlast = sym.last;

endmodule
